/* src/assert_macros.svh */
// Assertion macros for the deque RTL.
// No dependencies; taken in by `include in the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dbq_pkg.sv */
// Package for the bounded deque with search: sizes, operation and status codes,
// transaction structs and the sweep controller state type. No dependencies.
`timescale 1ns / 1ps

package dbq_pkg;

    // Storage sizing
    localparam int DEPTH  = 256;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 9;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed_value;
        logic                     found;
        logic [LEN_W-1:0]         length;
    } t_out_item;

    // Controller to cell chain: shift enable and the value fed into the tail cell
    typedef struct packed {
        logic              shift;
        logic [DATA_W-1:0] tail;
    } t_chain_ctl;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

endpackage

/* src/dbq_cell.sv */
// One storage cell of the deque ring: holds one entry and takes its neighbour's
// entry on every shift. Depends on dbq_pkg.
`timescale 1ns / 1ps

module dbq_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic [dbq_pkg::DATA_W-1:0]    i_d,
    output logic [dbq_pkg::DATA_W-1:0]    o_q
);

    logic [dbq_pkg::DATA_W-1:0] r_q;
    logic [dbq_pkg::DATA_W-1:0] n_q;

    // Move one place toward the head on a shift, otherwise hold
    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* src/dbq_ctrl.sv */
// Sweep controller for the deque: decodes a request, rotates the cell ring once
// round, rebuilds the order at the tail and registers the result.
// Depends on dbq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dbq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dbq_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dbq_pkg::t_out_item            o_out_data,
    input  logic [dbq_pkg::DATA_W-1:0]    i_head,
    input  logic [dbq_pkg::DATA_W-1:0]    i_next,
    output dbq_pkg::t_chain_ctl           o_chain
);

    // Control state
    dbq_pkg::t_state                r_state, n_state;
    logic [dbq_pkg::CNT_W-1:0]      r_count, n_count;
    logic [dbq_pkg::IDX_W-1:0]      r_step,  n_step;
    logic                           r_out_valid, n_out_valid;

    // Per-transaction working registers
    logic [dbq_pkg::MODE_W-1:0]     r_op,      n_op;
    logic [dbq_pkg::DATA_W-1:0]     r_key,     n_key;
    logic [dbq_pkg::IDX_W-1:0]      r_tgt,     n_tgt;
    logic [dbq_pkg::DATA_W-1:0]     r_prev,    n_prev;
    logic [dbq_pkg::DATA_W-1:0]     r_removed, n_removed;
    logic                           r_found,   n_found;
    dbq_pkg::t_out_item             r_out,     n_out;

    // Decode
    logic                           w_out_free;
    logic                           w_accept;
    logic                           w_empty;
    logic                           w_full;
    logic                           w_bad_pos;
    logic [dbq_pkg::CMP_W-1:0]      w_pos_ext;
    logic [dbq_pkg::CMP_W-1:0]      w_cnt_ext;
    logic                           w_sweep;
    logic [dbq_pkg::STAT_W-1:0]     w_imm_status;
    logic [dbq_pkg::IDX_W-1:0]      w_tgt;
    logic [dbq_pkg::CNT_W-1:0]      w_new_count;

    // Sweep datapath
    logic                           w_last;
    logic                           w_in_list;
    logic                           w_is_del;
    logic [dbq_pkg::DATA_W-1:0]     w_tail;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != dbq_pkg::ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == dbq_pkg::CNT_W'(dbq_pkg::DEPTH));
    assign w_pos_ext = dbq_pkg::CMP_W'(i_in_data.position);
    assign w_cnt_ext = dbq_pkg::CMP_W'(r_count);
    assign w_bad_pos = (w_pos_ext == '0) || (w_pos_ext > w_cnt_ext);

    // Request decode: which requests need a sweep, and the target slot
    always_comb begin
        w_sweep      = 1'b0;
        w_imm_status = dbq_pkg::STAT_OK;
        w_tgt        = '0;
        w_new_count  = r_count;
        case (i_in_data.mode)
            dbq_pkg::MODE_INS_FRONT: begin
                if (w_full) begin
                    w_imm_status = dbq_pkg::STAT_FULL;
                end else begin
                    w_sweep     = 1'b1;
                    w_new_count = r_count + 1'b1;
                end
            end
            dbq_pkg::MODE_INS_BACK: begin
                if (w_full) begin
                    w_imm_status = dbq_pkg::STAT_FULL;
                end else begin
                    w_sweep     = 1'b1;
                    w_tgt       = dbq_pkg::IDX_W'(r_count);
                    w_new_count = r_count + 1'b1;
                end
            end
            dbq_pkg::MODE_DEL_FRONT: begin
                if (w_empty) begin
                    w_imm_status = dbq_pkg::STAT_EMPTY;
                end else begin
                    w_sweep     = 1'b1;
                    w_new_count = r_count - 1'b1;
                end
            end
            dbq_pkg::MODE_DEL_BACK: begin
                if (w_empty) begin
                    w_imm_status = dbq_pkg::STAT_EMPTY;
                end else begin
                    w_sweep     = 1'b1;
                    w_tgt       = dbq_pkg::IDX_W'(r_count - 1'b1);
                    w_new_count = r_count - 1'b1;
                end
            end
            dbq_pkg::MODE_DEL_POS: begin
                if (w_empty) begin
                    w_imm_status = dbq_pkg::STAT_EMPTY;
                end else if (w_bad_pos) begin
                    w_imm_status = dbq_pkg::STAT_RANGE;
                end else begin
                    w_sweep     = 1'b1;
                    w_tgt       = dbq_pkg::IDX_W'(w_pos_ext - 1'b1);
                    w_new_count = r_count - 1'b1;
                end
            end
            dbq_pkg::MODE_SEARCH: begin
                if (w_empty) begin
                    w_imm_status = dbq_pkg::STAT_EMPTY;
                end else begin
                    w_sweep = 1'b1;
                end
            end
            default: begin
                w_sweep = 1'b0;
            end
        endcase
    end

    assign w_last    = (r_step == dbq_pkg::IDX_W'(dbq_pkg::DEPTH - 1));
    assign w_in_list = (dbq_pkg::CNT_W'(r_step) < r_count);
    assign w_is_del  = (r_op == dbq_pkg::MODE_DEL_FRONT) || (r_op == dbq_pkg::MODE_DEL_BACK)
                    || (r_op == dbq_pkg::MODE_DEL_POS);

    // Tail feed: after a full turn, cell k holds what was fed at step k
    always_comb begin
        case (r_op)
            dbq_pkg::MODE_INS_FRONT: w_tail = (r_step == '0) ? r_key : r_prev;
            dbq_pkg::MODE_INS_BACK:  w_tail = (r_step == r_tgt) ? r_key : i_head;
            dbq_pkg::MODE_DEL_FRONT,
            dbq_pkg::MODE_DEL_POS:   w_tail = (r_step >= r_tgt) ? i_next : i_head;
            default:                 w_tail = i_head;
        endcase
    end

    assign o_chain.shift = (r_state == dbq_pkg::ST_SWEEP);
    assign o_chain.tail  = w_tail;

    // Sequencing and result assembly
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_op        = r_op;
        n_key       = r_key;
        n_tgt       = r_tgt;
        n_prev      = r_prev;
        n_removed   = r_removed;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            dbq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op      = i_in_data.mode;
                    n_key     = i_in_data.value;
                    n_tgt     = w_tgt;
                    n_step    = '0;
                    n_removed = '0;
                    n_found   = 1'b0;
                    if (w_sweep) begin
                        n_state = dbq_pkg::ST_SWEEP;
                        n_count = w_new_count;
                    end else begin
                        n_out.status        = w_imm_status;
                        n_out.removed_value = '0;
                        n_out.found         = 1'b0;
                        n_out.length        = dbq_pkg::LEN_W'(r_count);
                        n_out_valid         = 1'b1;
                    end
                end
            end
            dbq_pkg::ST_SWEEP: begin
                n_prev = i_head;
                n_step = r_step + 1'b1;
                if (w_is_del && (r_step == r_tgt)) begin
                    n_removed = i_head;
                end
                if ((r_op == dbq_pkg::MODE_SEARCH) && w_in_list && (i_head == r_key)) begin
                    n_found = 1'b1;
                end
                if (w_last) begin
                    n_state = dbq_pkg::ST_DONE;
                end
            end
            dbq_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out.status        = dbq_pkg::STAT_OK;
                    n_out.removed_value = r_removed;
                    n_out.found         = r_found;
                    n_out.length        = dbq_pkg::LEN_W'(r_count);
                    n_out_valid         = 1'b1;
                    n_state             = dbq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dbq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dbq_pkg::ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_tgt     <= n_tgt;
        r_prev    <= n_prev;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= dbq_pkg::CNT_W'(dbq_pkg::DEPTH),
        "entry count beyond depth")
    `ASSERT_NEXT(a_sweep_ends, i_clk, i_rst_n, (r_state == dbq_pkg::ST_SWEEP) && w_last,
        r_state == dbq_pkg::ST_DONE, "sweep did not end after one full turn")
    `ASSERT_NEXT(a_sweep_starts, i_clk, i_rst_n, w_accept && w_sweep,
        (r_state == dbq_pkg::ST_SWEEP) && (r_step == '0), "sweep did not start at step zero")
    `ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n, (r_state == dbq_pkg::ST_DONE) && w_out_free,
        o_out_valid && (r_state == dbq_pkg::ST_IDLE), "finished sweep left no result")

endmodule

/* src/bounded_deque_with_search_unit.sv */
// Requests answered at decode (full, empty, bad position, unused mode) give their
// result in the cycle after acceptance; others pass through ST_SWEEP and ST_DONE first.
// Throughput: one transaction at a time; a sweeping one holds the unit for one full
// rotation of the cell ring through its single head and tail ports; transactions
// answered at decode can follow one per cycle while the output is not stalled.
// Reset (synchronous, active low) empties the list; stored entries keep no reset.
`timescale 1ns / 1ps

module bounded_deque_with_search_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dbq_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dbq_pkg::t_out_item    o_out_data
);

    logic [dbq_pkg::DATA_W-1:0] w_q [dbq_pkg::DEPTH];
    dbq_pkg::t_chain_ctl        w_chain;

    // Ring of cells: each takes its neighbour, the last takes the controller feed
    for (genvar k = 0; k < dbq_pkg::DEPTH; k++) begin : g_cell
        if (k == dbq_pkg::DEPTH - 1) begin : g_tail
            dbq_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_chain.shift),
                .i_d     (w_chain.tail),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            dbq_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_chain.shift),
                .i_d     (w_q[k+1]),
                .o_q     (w_q[k])
            );
        end
    end

    // Sequencer and result register
    dbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_head      (w_q[0]),
        .i_next      (w_q[1]),
        .o_chain     (w_chain)
    );

endmodule
